FILE: src/tllc_pkg.sv
// Shared types and constants for the three level LRU cache model.
// No dependencies.
package tllc_pkg;
  localparam int unsigned L1_ENTRIES = 32;
  localparam int unsigned L2_ENTRIES = 128;
  localparam int unsigned L3_ENTRIES = 512;
  localparam int unsigned TAG_BITS   = 32;
  localparam int unsigned L1_AW = $clog2(L1_ENTRIES);
  localparam int unsigned L2_AW = $clog2(L2_ENTRIES);
  localparam int unsigned L3_AW = $clog2(L3_ENTRIES);
  localparam int unsigned L1_FW = $clog2(L1_ENTRIES + 1);
  localparam int unsigned L2_FW = $clog2(L2_ENTRIES + 1);
  localparam int unsigned L3_FW = $clog2(L3_ENTRIES + 1);
  localparam int unsigned PTR_W = L3_FW;
  localparam int unsigned LAT_W = 10;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    LVL_L1   = 3'd0,
    LVL_L2   = 3'd1,
    LVL_L3   = 3'd2,
    LVL_MISS = 3'd3,
    LVL_TICK = 3'd4
  } lvl_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L1_LAT   = 3'd0,
    CFG_L2_LAT   = 3'd1,
    CFG_L3_LAT   = 3'd2,
    CFG_RAM_LAT  = 3'd3,
    CFG_COMP_LAT = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCMP,
    ST_INS,
    ST_SHRD,
    ST_SHWR,
    ST_TAG,
    ST_DONE
  } state_e;
endpackage

FILE: src/three_level_lru_cache_model.sv
// Top level of the three level LRU cache model: sequencer, tag stores, counters.
// Depends on tllc_pkg.
//
// Usage: an input request (action_i, block_id_i) is taken on in_valid_i and
// in_ready_o. A compute tick goes straight to the result state. An access
// walks the valid entries of L1, then L2, then L3, reading and comparing one
// entry at a time through one shared tag comparator and the registered read
// port of each store. A hit or a fill then moves the younger entries down by
// one, with a read and a write state per moved entry, followed by the tag write.
// One result request is presented on out_valid_o until out_ready_i; the
// block takes the next input while a result still waits, and only holds the
// following result back until the output register is free.
// Configuration writes on cfg_valid_i are always ready and must be made while
// the block is idle. Reset clears all fill counts, both counters and sets
// the latencies to their defaults; no clearing pass is needed.
module three_level_lru_cache_model
  import tllc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LAT_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 action_i,
  input  logic [31:0]          block_id_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           hit_level_o,
  output logic [LAT_W-1:0]     latency_o,
  output logic [SUM_W-1:0]     cycle_total_o,
  output logic [CNT_W-1:0]     ram_accesses_o
);

  // Latency registers.
  logic [LAT_W-1:0] l1_lat_q, l2_lat_q, l3_lat_q, ram_lat_q, comp_lat_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_lat_q   <= LAT_W'(4);
      l2_lat_q   <= LAT_W'(12);
      l3_lat_q   <= LAT_W'(40);
      ram_lat_q  <= LAT_W'(200);
      comp_lat_q <= LAT_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_L1_LAT:   l1_lat_q   <= cfg_data_i;
        CFG_L2_LAT:   l2_lat_q   <= cfg_data_i;
        CFG_L3_LAT:   l3_lat_q   <= cfg_data_i;
        CFG_RAM_LAT:  ram_lat_q  <= cfg_data_i;
        CFG_COMP_LAT: comp_lat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_e             state_q, state_d;
  lvl_e               cur_q, cur_d;
  lvl_e               res_q, res_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [PTR_W-1:0]   end_q, end_d;
  logic [PTR_W-1:0]   wa_q, wa_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [L1_FW-1:0]   l1_fill_q, l1_fill_d;
  logic [L2_FW-1:0]   l2_fill_q, l2_fill_d;
  logic [L3_FW-1:0]   l3_fill_q, l3_fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   miss_q, miss_d;
  logic               ovld_q, ovld_d;
  lvl_e               olvl_q, olvl_d;
  logic [LAT_W-1:0]   olat_q, olat_d;

  // Tag stores, each ordered from least recent (address 0) to most recent.
  logic [TAG_BITS-1:0] l1_mem [L1_ENTRIES];
  logic [TAG_BITS-1:0] l2_mem [L2_ENTRIES];
  logic [TAG_BITS-1:0] l3_mem [L3_ENTRIES];
  logic [TAG_BITS-1:0] l1_rd_q, l2_rd_q, l3_rd_q;
  logic                we;
  logic [PTR_W-1:0]    waddr;
  logic [TAG_BITS-1:0] wdata;
  logic [TAG_BITS-1:0] rd_cur;
  logic [PTR_W-1:0]    fill_cur, cap_cur;
  logic [SUM_W:0]      sum_ext;
  logic [LAT_W-1:0]    lat_sel;

  always_ff @(posedge clk_i) begin
    l1_rd_q <= l1_mem[ptr_q[L1_AW-1:0]];
    l2_rd_q <= l2_mem[ptr_q[L2_AW-1:0]];
    l3_rd_q <= l3_mem[ptr_q[L3_AW-1:0]];
    if (we && cur_q == LVL_L1) l1_mem[waddr[L1_AW-1:0]] <= wdata;
    if (we && cur_q == LVL_L2) l2_mem[waddr[L2_AW-1:0]] <= wdata;
    if (we && cur_q == LVL_L3) l3_mem[waddr[L3_AW-1:0]] <= wdata;
  end

  always_comb begin
    case (cur_q)
      LVL_L1: begin
        rd_cur   = l1_rd_q;
        fill_cur = PTR_W'(l1_fill_q);
        cap_cur  = PTR_W'(L1_ENTRIES);
      end
      LVL_L2: begin
        rd_cur   = l2_rd_q;
        fill_cur = PTR_W'(l2_fill_q);
        cap_cur  = PTR_W'(L2_ENTRIES);
      end
      default: begin
        rd_cur   = l3_rd_q;
        fill_cur = PTR_W'(l3_fill_q);
        cap_cur  = PTR_W'(L3_ENTRIES);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cur_q     <= LVL_L1;
      res_q     <= LVL_TICK;
      ptr_q     <= '0;
      end_q     <= '0;
      wa_q      <= '0;
      l1_fill_q <= '0;
      l2_fill_q <= '0;
      l3_fill_q <= '0;
      sum_q     <= '0;
      miss_q    <= '0;
      ovld_q    <= 1'b0;
      olvl_q    <= LVL_TICK;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      res_q     <= res_d;
      ptr_q     <= ptr_d;
      end_q     <= end_d;
      wa_q      <= wa_d;
      l1_fill_q <= l1_fill_d;
      l2_fill_q <= l2_fill_d;
      l3_fill_q <= l3_fill_d;
      sum_q     <= sum_d;
      miss_q    <= miss_d;
      ovld_q    <= ovld_d;
      olvl_q    <= olvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    olat_q <= olat_d;
  end

  always_comb begin
    case (res_q)
      LVL_L1:   lat_sel = l1_lat_q;
      LVL_L2:   lat_sel = l2_lat_q;
      LVL_L3:   lat_sel = l3_lat_q;
      LVL_MISS: lat_sel = ram_lat_q;
      default:  lat_sel = comp_lat_q;
    endcase
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(lat_sel);
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    res_d     = res_q;
    ptr_d     = ptr_q;
    end_d     = end_q;
    wa_d      = wa_q;
    tag_d     = tag_q;
    l1_fill_d = l1_fill_q;
    l2_fill_d = l2_fill_q;
    l3_fill_d = l3_fill_q;
    sum_d     = sum_q;
    miss_d    = miss_q;
    olvl_d    = olvl_q;
    olat_d    = olat_q;
    ovld_d    = ovld_q && !out_ready_i;
    we        = 1'b0;
    waddr     = wa_q;
    wdata     = tag_q;
    in_ready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          tag_d = block_id_i[TAG_BITS-1:0];
          ptr_d = '0;
          cur_d = LVL_L1;
          if (action_i) begin
            state_d = ST_SRD;
          end else begin
            res_d   = LVL_TICK;
            state_d = ST_DONE;
          end
        end
      end
      ST_SRD: begin
        if (ptr_q < fill_cur) begin
          state_d = ST_SCMP;
        end else if (cur_q != LVL_L3) begin
          cur_d   = lvl_e'(cur_q + 3'd1);
          ptr_d   = '0;
        end else begin
          res_d   = LVL_MISS;
          state_d = ST_INS;
        end
      end
      ST_SCMP: begin
        ptr_d = ptr_q + PTR_W'(1);
        if (rd_cur == tag_q) begin
          // Hit: shift the younger entries down and put the tag on top.
          res_d   = cur_q;
          end_d   = fill_cur;
          state_d = ST_SHRD;
        end else begin
          state_d = ST_SRD;
        end
      end
      ST_INS: begin
        if (fill_cur >= cap_cur) begin
          ptr_d   = PTR_W'(1);
          end_d   = cap_cur;
          state_d = ST_SHRD;
        end else begin
          wa_d    = fill_cur;
          state_d = ST_TAG;
          case (cur_q)
            LVL_L1:  l1_fill_d = l1_fill_q + L1_FW'(1);
            LVL_L2:  l2_fill_d = l2_fill_q + L2_FW'(1);
            default: l3_fill_d = l3_fill_q + L3_FW'(1);
          endcase
        end
      end
      ST_SHRD: begin
        if (ptr_q < end_q) begin
          state_d = ST_SHWR;
        end else begin
          wa_d    = end_q - PTR_W'(1);
          state_d = ST_TAG;
        end
      end
      ST_SHWR: begin
        we      = 1'b1;
        waddr   = ptr_q - PTR_W'(1);
        wdata   = rd_cur;
        ptr_d   = ptr_q + PTR_W'(1);
        state_d = ST_SHRD;
      end
      ST_TAG: begin
        we = 1'b1;
        if (cur_q == LVL_L1) begin
          state_d = ST_DONE;
        end else if (res_q == LVL_MISS) begin
          cur_d   = lvl_e'(cur_q - 3'd1);
          state_d = ST_INS;
        end else begin
          cur_d   = LVL_L1;
          state_d = ST_INS;
        end
      end
      ST_DONE: begin
        if (!ovld_q || out_ready_i) begin
          ovld_d  = 1'b1;
          olvl_d  = res_q;
          olat_d  = lat_sel;
          sum_d   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
          if (res_q == LVL_MISS && miss_q != {CNT_W{1'b1}}) begin
            miss_d = miss_q + CNT_W'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o    = ovld_q;
  assign hit_level_o    = olvl_q;
  assign latency_o      = olat_q;
  assign cycle_total_o  = sum_q;
  assign ram_accesses_o = miss_q;

endmodule
